// ----- design/vertex_normal_hillshade_assert.svh -----
// Assertion macros for the vertex normal hillshade block.
// Taken in by the checker file; no other dependencies.
`ifndef VERTEX_NORMAL_HILLSHADE_ASSERT_SVH
`define VERTEX_NORMAL_HILLSHADE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define VNH_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("vnh: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define VNH_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("vnh: next-cycle check failed");

`endif

// ----- design/vnh_pkg.sv -----
// Shared types and constants for the vertex normal hillshade block.
// No dependencies; compiled before every other file.
`timescale 1ns / 1ps

package vnh_pkg;

    localparam int MAX_VERTICES_DEF = 1024;

    localparam int OP_W      = 2;
    localparam int IDX_W     = 10;
    localparam int POS_W     = 24;
    localparam int VEC_W     = 3 * POS_W;
    localparam int NRM_W     = 16;
    localparam int SHADE_W   = 16;
    localparam int VCOUNT_W  = 11;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    localparam int EDGE_W    = POS_W + 1;
    localparam int MUL_W     = 32;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int MAG_W     = 50;
    localparam int MAG_LIM_W = 30;
    localparam int SQ_W      = 63;
    localparam int ROOT_W    = 32;
    localparam int FRAC_N    = 14;
    localparam int NUM_W     = ROOT_W + FRAC_N;
    localparam int QUO_W     = FRAC_N + 1;
    localparam int DOT_W     = 31;
    localparam int STEP_W    = 6;
    localparam int SHADE_FRAC = 28;

    localparam int Q14_ONE   = 16384;
    localparam int Q15_ONE   = 32768;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD = 2'd0,
        OP_TRI  = 2'd1,
        OP_READ = 2'd2
    } vnh_opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VCOUNT  = 3'd0,
        CFG_LIGHT_X = 3'd1,
        CFG_LIGHT_Y = 3'd2,
        CFG_LIGHT_Z = 3'd3,
        CFG_AMBIENT = 3'd4
    } vnh_cfg_t;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_LOAD, ST_PRD, ST_CROSS, ST_SHIFT,
        ST_SQ, ST_SQRT, ST_DIV, ST_ACC, ST_RDSUM, ST_DOT, ST_SHADE, ST_EMIT
    } vnh_state_t;

    typedef enum logic [3:0] {
        PH_IDLE, PH_CLEAR, PH_LOAD, PH_PRD, PH_CROSS, PH_SHIFT, PH_SQ,
        PH_SQRT, PH_DIV, PH_ACC, PH_RDSUM, PH_DOT, PH_SHADE, PH_EMIT
    } vnh_phase_t;

    typedef struct packed {
        logic              capture;
        vnh_phase_t        phase;
        logic [STEP_W-1:0] step;
    } vnh_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            tri_ok;
        logic            clr_last;
        logic            shift_done;
        logic            out_free;
    } vnh_stat_t;

endpackage

// ----- design/vnh_req_if.sv -----
// Request channel: valid/ready handshake carrying one command item.
// Depends on vnh_pkg for field widths.
`timescale 1ns / 1ps

interface vnh_req_if;
    import vnh_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          opcode;
    logic [IDX_W-1:0]         index_a;
    logic [IDX_W-1:0]         index_b;
    logic [IDX_W-1:0]         index_c;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;

    modport source (output valid, opcode, index_a, index_b, index_c, pos_x, pos_y, pos_z,
                    input ready);
    modport sink   (input valid, opcode, index_a, index_b, index_c, pos_x, pos_y, pos_z,
                    output ready);
endinterface

// ----- design/vnh_rsp_if.sv -----
// Response channel: valid/ready handshake carrying one vertex result.
// Depends on vnh_pkg for field widths.
`timescale 1ns / 1ps

interface vnh_rsp_if;
    import vnh_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [IDX_W-1:0]         vertex_index;
    logic signed [NRM_W-1:0]  normal_x;
    logic signed [NRM_W-1:0]  normal_y;
    logic signed [NRM_W-1:0]  normal_z;
    logic [SHADE_W-1:0]       shade;

    modport source (output valid, vertex_index, normal_x, normal_y, normal_z, shade,
                    input ready);
    modport sink   (input valid, vertex_index, normal_x, normal_y, normal_z, shade,
                    output ready);
endinterface

// ----- design/vnh_ctrl.sv -----
// Sequencer for the vertex normal hillshade block: state machine and step counter.
// Depends on vnh_pkg; drives the datapath through vnh_cmd_t.
`timescale 1ns / 1ps

module vnh_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  vnh_pkg::vnh_stat_t stat,
    output vnh_pkg::vnh_cmd_t  cmd
);
    import vnh_pkg::*;

    vnh_state_t        state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg + STEP_W'(1);
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.phase   = PH_IDLE;
        cmd.step    = cnt_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.phase = PH_CLEAR;
                cnt_next  = '0;
                if (stat.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cnt_next = '0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                cnt_next = '0;
                unique case (stat.op)
                    OP_LOAD: state_next = ST_LOAD;
                    OP_TRI:  state_next = stat.tri_ok ? ST_PRD : ST_IDLE;
                    OP_READ: state_next = ST_RDSUM;
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_LOAD:
            begin
                cmd.phase  = PH_LOAD;
                state_next = ST_IDLE;
            end
            ST_PRD:
            begin
                cmd.phase = PH_PRD;
                if (cnt_reg == STEP_W'(3))
                begin
                    cnt_next   = '0;
                    state_next = ST_CROSS;
                end
            end
            ST_CROSS:
            begin
                cmd.phase = PH_CROSS;
                if (cnt_reg == STEP_W'(6))
                begin
                    cnt_next   = '0;
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                cmd.phase = PH_SHIFT;
                cnt_next  = '0;
                if (stat.shift_done)
                    state_next = ST_SQ;
            end
            ST_SQ:
            begin
                cmd.phase = PH_SQ;
                if (cnt_reg == STEP_W'(3))
                begin
                    cnt_next   = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                cmd.phase = PH_SQRT;
                if (cnt_reg == STEP_W'(31))
                begin
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // three components, sixteen steps each
                cmd.phase = PH_DIV;
                if (cnt_reg == STEP_W'(47))
                begin
                    cnt_next   = '0;
                    state_next = (stat.op == OP_TRI) ? ST_ACC : ST_DOT;
                end
            end
            ST_ACC:
            begin
                cmd.phase = PH_ACC;
                if (cnt_reg == STEP_W'(5))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_RDSUM:
            begin
                cmd.phase = PH_RDSUM;
                if (cnt_reg == STEP_W'(1))
                begin
                    cnt_next   = '0;
                    state_next = ST_SHIFT;
                end
            end
            ST_DOT:
            begin
                cmd.phase = PH_DOT;
                if (cnt_reg == STEP_W'(3))
                begin
                    cnt_next   = '0;
                    state_next = ST_SHADE;
                end
            end
            ST_SHADE:
            begin
                cmd.phase = PH_SHADE;
                if (cnt_reg == STEP_W'(1))
                begin
                    cnt_next   = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cmd.phase = PH_EMIT;
                cnt_next  = '0;
                if (stat.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                cnt_next   = '0;
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/vnh_datapath.sv -----
// Datapath: position and normal-sum memories, shared multiplier, bit-serial
// square root and divider, result register. Depends on vnh_pkg.
`timescale 1ns / 1ps

module vnh_datapath #(
    parameter int MAX_VERTICES = vnh_pkg::MAX_VERTICES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [vnh_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vnh_pkg::CFG_W-1:0]          cfg_data,
    input  logic [vnh_pkg::OP_W-1:0]           opcode,
    input  logic [vnh_pkg::IDX_W-1:0]          index_a,
    input  logic [vnh_pkg::IDX_W-1:0]          index_b,
    input  logic [vnh_pkg::IDX_W-1:0]          index_c,
    input  logic signed [vnh_pkg::POS_W-1:0]   pos_x,
    input  logic signed [vnh_pkg::POS_W-1:0]   pos_y,
    input  logic signed [vnh_pkg::POS_W-1:0]   pos_z,
    input  vnh_pkg::vnh_cmd_t                  cmd,
    output vnh_pkg::vnh_stat_t                 stat,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [vnh_pkg::IDX_W-1:0]          vertex_index,
    output logic signed [vnh_pkg::NRM_W-1:0]   normal_x,
    output logic signed [vnh_pkg::NRM_W-1:0]   normal_y,
    output logic signed [vnh_pkg::NRM_W-1:0]   normal_z,
    output logic [vnh_pkg::SHADE_W-1:0]        shade
);
    import vnh_pkg::*;

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam logic [31:0] MAXV = 32'(MAX_VERTICES);
    localparam logic signed [PROD_W-1:0] SHADE_TOP = 64'sh0000_0800_0000_0000;
    localparam logic signed [PROD_W-1:0] SHADE_HALF = 64'sh0000_0000_0800_0000;

    function automatic logic signed [POS_W-1:0] vcomp(input logic [VEC_W-1:0] v,
                                                      input int i);
        vcomp = signed'(v[(2 - i) * POS_W +: POS_W]);
    endfunction

    function automatic logic [POS_W-1:0] sat_add(input logic signed [POS_W-1:0] s,
                                                 input logic signed [NRM_W-1:0] q);
        logic signed [POS_W:0] t;
        t = (POS_W + 1)'(s) + (POS_W + 1)'(q);
        if (t[POS_W] != t[POS_W-1])
            sat_add = t[POS_W] ? {1'b1, {(POS_W - 1){1'b0}}} : {1'b0, {(POS_W - 1){1'b1}}};
        else
            sat_add = t[POS_W-1:0];
    endfunction

    function automatic logic [MAG_W-1:0] mag64(input logic signed [PROD_W-1:0] v);
        mag64 = MAG_W'(v[PROD_W-1] ? -v : v);
    endfunction

    // configuration
    logic [VCOUNT_W-1:0]     vcount_reg;
    logic signed [NRM_W-1:0] light_reg [3];
    logic [CFG_W-1:0]        amb_reg;

    // captured item
    logic [OP_W-1:0]  op_reg;
    logic [IDX_W-1:0] ia_reg, ib_reg, ic_reg;
    logic [VEC_W-1:0] pos_in_reg;

    // memories
    logic [VEC_W-1:0] pos_mem [MAX_VERTICES];
    logic [VEC_W-1:0] sum_mem [MAX_VERTICES];
    logic [VEC_W-1:0] pos_rd_reg, sum_rd_reg;
    logic             pos_we, sum_we;
    logic [AW-1:0]    pos_raddr, sum_raddr, sum_waddr;
    logic [VEC_W-1:0] sum_wdata;
    logic [AW-1:0]    clr_ptr_reg, clr_ptr_next;

    // arithmetic
    logic [VEC_W-1:0]          pa_reg;
    logic signed [EDGE_W-1:0]  e1_reg [3];
    logic signed [EDGE_W-1:0]  e2_reg [3];
    logic [MAG_W-1:0]          mag_reg [3];
    logic                      neg_reg [3];
    logic signed [NRM_W-1:0]   q_reg [3];
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  prod_reg, acc_reg, acc_sum, cross_diff;
    logic [SQ_W-1:0]           sq_x_reg, sq_r_reg, sq_bit_reg, sq_t;
    logic [ROOT_W-1:0]         root;
    logic [NUM_W-1:0]          rem_reg, den_reg;
    logic [QUO_W-1:0]          quo_reg, quo_next, qmag;
    logic                      div_ge;
    logic signed [NRM_W-1:0]   qs;
    logic [DOT_W-1:0]          dot_reg;
    logic [SHADE_W-1:0]        shade_reg;
    logic signed [PROD_W-1:0]  shade_sum, shade_cl, shade_rnd;
    logic signed [CFG_W+1:0]   amb_comp;
    logic [1:0]                ksel, csel, dsel;
    logic [IDX_W-1:0]          corner_prd, corner_acc;
    logic                      a_ok, out_valid_reg, out_valid_next;

    logic [IDX_W-1:0]        out_idx_reg;
    logic signed [NRM_W-1:0] out_n_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg   <= '0;
            light_reg[0] <= '0;
            light_reg[1] <= '0;
            light_reg[2] <= NRM_W'(Q14_ONE);
            amb_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_VCOUNT:  vcount_reg   <= cfg_data[VCOUNT_W-1:0];
                CFG_LIGHT_X: light_reg[0] <= signed'(cfg_data);
                CFG_LIGHT_Y: light_reg[1] <= signed'(cfg_data);
                CFG_LIGHT_Z: light_reg[2] <= signed'(cfg_data);
                CFG_AMBIENT: amb_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= opcode;
            ia_reg     <= index_a;
            ib_reg     <= index_b;
            ic_reg     <= index_c;
            pos_in_reg <= {pos_x, pos_y, pos_z};
        end
    end

    assign a_ok = 32'(ia_reg) < MAXV;

    always_comb
    begin
        stat.op         = op_reg;
        stat.tri_ok     = a_ok && (32'(ib_reg) < MAXV) && (32'(ic_reg) < MAXV)
                          && (VCOUNT_W'(ia_reg) < vcount_reg)
                          && (VCOUNT_W'(ib_reg) < vcount_reg)
                          && (VCOUNT_W'(ic_reg) < vcount_reg);
        stat.clr_last   = clr_ptr_reg == AW'(MAX_VERTICES - 1);
        stat.shift_done = (mag_reg[0][MAG_W-1:MAG_LIM_W] == '0)
                          && (mag_reg[1][MAG_W-1:MAG_LIM_W] == '0)
                          && (mag_reg[2][MAG_W-1:MAG_LIM_W] == '0);
        stat.out_free   = !out_valid_reg || out_ready;
    end

    // corner and component selects
    always_comb
    begin
        case (cmd.step[1:0])
            2'd0:    corner_prd = ia_reg;
            2'd1:    corner_prd = ib_reg;
            default: corner_prd = ic_reg;
        endcase
        case (cmd.step[2:1])
            2'd0:    corner_acc = ia_reg;
            2'd1:    corner_acc = ib_reg;
            default: corner_acc = ic_reg;
        endcase
        ksel = (cmd.step[1:0] == 2'd3) ? 2'd2 : cmd.step[1:0];
        csel = cmd.step[2:1] - 2'd1;
        dsel = (cmd.step[5:4] == 2'd3) ? 2'd2 : cmd.step[5:4];
    end

    // memories; a sweep zeroes the sums after reset
    always_comb
    begin
        pos_we    = (cmd.phase == PH_LOAD) && a_ok;
        pos_raddr = AW'(corner_prd);
        sum_raddr = (cmd.phase == PH_ACC) ? AW'(corner_acc) : AW'(ia_reg);
        sum_we    = 1'b0;
        sum_waddr = AW'(ia_reg);
        sum_wdata = '0;
        case (cmd.phase)
            PH_CLEAR:
            begin
                sum_we    = 1'b1;
                sum_waddr = clr_ptr_reg;
            end
            PH_LOAD:
                sum_we = a_ok;
            PH_ACC:
            begin
                sum_we    = cmd.step[0];
                sum_waddr = AW'(corner_acc);
                for (int i = 0; i < 3; i++)
                    sum_wdata[(2 - i) * POS_W +: POS_W] =
                        sat_add(vcomp(sum_rd_reg, i), q_reg[i]);
            end
            default: ;
        endcase
        clr_ptr_next = (cmd.phase == PH_CLEAR) ? clr_ptr_reg + AW'(1) : clr_ptr_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
            pos_mem[AW'(ia_reg)] <= pos_in_reg;
        pos_rd_reg <= pos_mem[pos_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sum_we)
            sum_mem[sum_waddr] <= sum_wdata;
        sum_rd_reg <= sum_mem[sum_raddr];
    end

    // shared multiplier operands
    always_comb
    begin
        mul_a    = '0;
        mul_b    = '0;
        amb_comp = (CFG_W + 2)'(Q15_ONE) - signed'((CFG_W + 2)'(amb_reg));
        case (cmd.phase)
            PH_CROSS:
            begin
                case (cmd.step[2:0])
                    3'd0: begin mul_a = MUL_W'(e1_reg[1]); mul_b = MUL_W'(e2_reg[2]); end
                    3'd1: begin mul_a = MUL_W'(e1_reg[2]); mul_b = MUL_W'(e2_reg[1]); end
                    3'd2: begin mul_a = MUL_W'(e1_reg[2]); mul_b = MUL_W'(e2_reg[0]); end
                    3'd3: begin mul_a = MUL_W'(e1_reg[0]); mul_b = MUL_W'(e2_reg[2]); end
                    3'd4: begin mul_a = MUL_W'(e1_reg[0]); mul_b = MUL_W'(e2_reg[1]); end
                    3'd5: begin mul_a = MUL_W'(e1_reg[1]); mul_b = MUL_W'(e2_reg[0]); end
                    default: ;
                endcase
            end
            PH_SQ:
            begin
                mul_a = signed'(MUL_W'(mag_reg[ksel][MAG_LIM_W-1:0]));
                mul_b = mul_a;
            end
            PH_DOT:
            begin
                mul_a = MUL_W'(q_reg[ksel]);
                mul_b = MUL_W'(light_reg[ksel]);
            end
            PH_SHADE:
            begin
                mul_a = MUL_W'(amb_comp);
                mul_b = signed'(MUL_W'(dot_reg));
            end
            default: ;
        endcase
    end

    always_comb
    begin
        acc_sum    = acc_reg + prod_reg;
        cross_diff = acc_reg - prod_reg;
        sq_t       = sq_r_reg + sq_bit_reg;
        root       = sq_r_reg[ROOT_W-1:0];
        div_ge     = rem_reg >= den_reg;
        quo_next   = {quo_reg[QUO_W-2:0], div_ge};
        if (root == '0)
            qmag = '0;
        else if (quo_next > QUO_W'(Q14_ONE))
            qmag = QUO_W'(Q14_ONE);
        else
            qmag = quo_next;
        qs = signed'({1'b0, qmag});
        shade_sum = signed'({20'b0, amb_reg, 28'b0}) + prod_reg;
        if (shade_sum[PROD_W-1])
            shade_cl = '0;
        else if (shade_sum > SHADE_TOP)
            shade_cl = SHADE_TOP;
        else
            shade_cl = shade_sum;
        shade_rnd = shade_cl + SHADE_HALF;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (cmd.phase)
            PH_PRD:
            begin
                if (cmd.step[1:0] == 2'd1)
                    pa_reg <= pos_rd_reg;
                for (int i = 0; i < 3; i++)
                begin
                    if (cmd.step[1:0] == 2'd2)
                        e1_reg[i] <= EDGE_W'(vcomp(pos_rd_reg, i)) - EDGE_W'(vcomp(pa_reg, i));
                    if (cmd.step[1:0] == 2'd3)
                        e2_reg[i] <= EDGE_W'(vcomp(pos_rd_reg, i)) - EDGE_W'(vcomp(pa_reg, i));
                end
            end
            PH_CROSS:
            begin
                // products land in the cycle after their operands: odd steps start a term, even ones finish it
                if (cmd.step[0])
                    acc_reg <= prod_reg;
                else if (cmd.step != '0)
                begin
                    mag_reg[csel] <= mag64(cross_diff);
                    neg_reg[csel] <= cross_diff[PROD_W-1];
                end
            end
            PH_RDSUM:
            begin
                if (cmd.step[0])
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= a_ok ? mag64(PROD_W'(vcomp(sum_rd_reg, i))) : '0;
                        neg_reg[i] <= a_ok && sum_rd_reg[(3 - i) * POS_W - 1];
                    end
            end
            PH_SHIFT:
            begin
                if (!stat.shift_done)
                    for (int i = 0; i < 3; i++)
                        mag_reg[i] <= mag_reg[i] >> 1;
            end
            PH_SQ:
            begin
                if (cmd.step[1:0] == 2'd1)
                    acc_reg <= prod_reg;
                else if (cmd.step[1:0] == 2'd2)
                    acc_reg <= acc_sum;
                else if (cmd.step[1:0] == 2'd3)
                begin
                    sq_x_reg   <= SQ_W'(acc_sum);
                    sq_r_reg   <= '0;
                    sq_bit_reg <= {1'b1, {(SQ_W - 1){1'b0}}};
                end
            end
            PH_SQRT:
            begin
                if (sq_x_reg >= sq_t)
                begin
                    sq_x_reg <= sq_x_reg - sq_t;
                    sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                end
                else
                    sq_r_reg <= sq_r_reg >> 1;
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            PH_DIV:
            begin
                if (cmd.step[3:0] == 4'd0)
                begin
                    rem_reg <= NUM_W'({mag_reg[dsel][MAG_LIM_W-1:0], {FRAC_N{1'b0}}})
                               + NUM_W'(root >> 1);
                    den_reg <= {root, {FRAC_N{1'b0}}};
                    quo_reg <= '0;
                end
                else
                begin
                    if (div_ge)
                        rem_reg <= rem_reg - den_reg;
                    den_reg <= den_reg >> 1;
                    quo_reg <= quo_next;
                    if (cmd.step[3:0] == 4'd15)
                        q_reg[dsel] <= neg_reg[dsel] ? -qs : qs;
                end
            end
            PH_DOT:
            begin
                if (cmd.step[1:0] == 2'd1)
                    acc_reg <= prod_reg;
                else if (cmd.step[1:0] == 2'd2)
                    acc_reg <= acc_sum;
                else if (cmd.step[1:0] == 2'd3)
                    dot_reg <= acc_sum[PROD_W-1] ? '0 : DOT_W'(acc_sum);
            end
            PH_SHADE:
            begin
                if (cmd.step[0])
                    shade_reg <= shade_rnd[SHADE_FRAC + SHADE_W - 1:SHADE_FRAC];
            end
            PH_EMIT:
            begin
                if (stat.out_free)
                begin
                    out_idx_reg <= ia_reg;
                    for (int i = 0; i < 3; i++)
                        out_n_reg[i] <= q_reg[i];
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if ((cmd.phase == PH_EMIT) && stat.out_free)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            clr_ptr_reg   <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            clr_ptr_reg   <= clr_ptr_next;
        end
    end

    logic [SHADE_W-1:0] out_shade_reg;

    always_ff @(posedge clk)
    begin
        if ((cmd.phase == PH_EMIT) && stat.out_free)
            out_shade_reg <= shade_reg;
    end

    assign out_valid    = out_valid_reg;
    assign vertex_index = out_idx_reg;
    assign normal_x     = out_n_reg[0];
    assign normal_y     = out_n_reg[1];
    assign normal_z     = out_n_reg[2];
    assign shade        = out_shade_reg;

endmodule

// ----- design/vertex_normal_hillshade.sv -----
// Top level of the vertex normal hillshade block: sequencer plus datapath.
// Depends on vnh_pkg, vnh_req_if, vnh_rsp_if, vnh_ctrl and vnh_datapath.
//
// Takes one command at a time. After reset the normal sums are zeroed by a
// sweep over all MAX_VERTICES entries during which no request is taken
// (register writes still land). A triangle's cross-product components are
// shifted right until each fits in 30 bits; a triangle with an index out of
// range or not below the vertex count is skipped. A triangle and a vertex
// read both pass through the bit-serial square root (32 steps) and the
// shared restoring divider (16 steps per component). A finished result
// waits in an output register, so the next request is taken while it is
// unclaimed.
`timescale 1ns / 1ps

module vertex_normal_hillshade #(
    parameter int MAX_VERTICES = vnh_pkg::MAX_VERTICES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [vnh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vnh_pkg::CFG_W-1:0]     cfg_data,
    vnh_req_if.sink                       request,
    vnh_rsp_if.source                     response
);
    import vnh_pkg::*;

    vnh_cmd_t  cmd;
    vnh_stat_t stat;
    logic      req_ready;

    vnh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_ready (req_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    vnh_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .opcode       (request.opcode),
        .index_a      (request.index_a),
        .index_b      (request.index_b),
        .index_c      (request.index_c),
        .pos_x        (request.pos_x),
        .pos_y        (request.pos_y),
        .pos_z        (request.pos_z),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (response.valid),
        .out_ready    (response.ready),
        .vertex_index (response.vertex_index),
        .normal_x     (response.normal_x),
        .normal_y     (response.normal_y),
        .normal_z     (response.normal_z),
        .shade        (response.shade)
    );

    assign request.ready = req_ready;

endmodule

// ----- design/vnh_checker.sv -----
// Port-level checks for vertex_normal_hillshade, attached by bind.
// Depends on vnh_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "vertex_normal_hillshade_assert.svh"

module vnh_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              req_valid,
    input logic                              req_ready,
    input logic                              rsp_valid,
    input logic                              rsp_ready,
    input logic signed [vnh_pkg::NRM_W-1:0]  rsp_nx,
    input logic signed [vnh_pkg::NRM_W-1:0]  rsp_ny,
    input logic signed [vnh_pkg::NRM_W-1:0]  rsp_nz,
    input logic [vnh_pkg::SHADE_W-1:0]       rsp_shade
);
    import vnh_pkg::*;

    // one item at a time: no transfer right after an accepted one
    `VNH_ASSERT_NXT(a_one_at_a_time, clk, rst_n, req_valid && req_ready, !req_ready)

    // a result never appears in the cycle after a request transfer
    `VNH_ASSERT_NXT(a_no_instant_result, clk, rst_n, req_valid && req_ready, !$rose(rsp_valid))

    // results stay in range: unit normal in Q1.14, shade in zero..one
    `VNH_ASSERT_IMP(a_result_range, clk, rst_n, rsp_valid, (rsp_shade <= 16'd32768) && (rsp_nx <= 16'sd16384) && (rsp_nx >= -16'sd16384) && (rsp_ny <= 16'sd16384) && (rsp_ny >= -16'sd16384) && (rsp_nz <= 16'sd16384) && (rsp_nz >= -16'sd16384))

    // a stalled result is held
    `VNH_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_shade))

endmodule

bind vertex_normal_hillshade vnh_checker u_vnh_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .rsp_valid (response.valid),
    .rsp_ready (response.ready),
    .rsp_nx    (response.normal_x),
    .rsp_ny    (response.normal_y),
    .rsp_nz    (response.normal_z),
    .rsp_shade (response.shade)
);
